// ===== hw/rtl/fractal_orbit_density_histogram_assert.svh =====
// Assertion macros shared by the orbit density histogram RTL.
// Uses clk_i and rst_ni of the including module; empty under SYNTHESIS.
`ifndef FRACTAL_ORBIT_DENSITY_HISTOGRAM_ASSERT_SVH
`define FRACTAL_ORBIT_DENSITY_HISTOGRAM_ASSERT_SVH
`ifndef SYNTHESIS
`define FODH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define FODH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FODH_ASSERT(lbl, prop, msg)
`define FODH_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/fodh_pkg.sv =====
// Types, constants and codes of the orbit density histogram.
// Used by every module of the block; depends on nothing.
`default_nettype none

package fodh_pkg;

  localparam int GridScale = 128;
  localparam int FracBits  = 26;
  localparam int CountBits = 32;

  localparam int ScaleBits = $clog2(GridScale);
  localparam int GridCols  = 3 * GridScale;
  localparam int GridRows  = 2 * GridScale;
  localparam int BinTotal  = GridCols * GridRows;
  localparam int BinAw     = $clog2(BinTotal);

  localparam int ColBits  = 9;
  localparam int RowBits  = 8;
  localparam int LenBits  = 16;
  localparam int HitsBits = 16;
  localparam int ApbDw    = 32;
  localparam int ApbAw    = 3;

  // orbit value, multiplier operand and product widths
  localparam int ZW = FracBits + 8;
  localparam int MW = FracBits + 5;
  localparam int PW = 2 * MW;

  localparam logic signed [ZW-1:0] FxOne        = ZW'(64'sd1 <<< FracBits);
  localparam logic signed [ZW-1:0] FxTwo        = ZW'(64'sd2 <<< FracBits);
  localparam logic signed [ZW-1:0] FxFour       = ZW'(64'sd4 <<< FracBits);
  localparam logic signed [ZW-1:0] FxMinusOne   = ZW'(-(64'sd1 <<< FracBits));
  localparam logic signed [ZW-1:0] FxMinusTwo   = ZW'(-(64'sd2 <<< FracBits));
  localparam logic signed [ZW-1:0] FxMinusFour  = ZW'(-(64'sd4 <<< FracBits));
  localparam logic signed [PW-1:0] SqLimit      = PW'(64'sd16 <<< FracBits);

  localparam logic [LenBits-1:0]   OrbitLenReset = LenBits'(1000);
  localparam logic [CountBits-1:0] CountMax      = '1;

  typedef enum logic [1:0] {
    OP_TRACE = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } opcode_e;

  typedef enum logic [ApbAw-1:0] {
    REG_ORBIT_LENGTH = 3'd0
  } reg_addr_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD,
    ST_LOOK,
    ST_WAIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [ColBits-1:0] pixel_col;
    logic [RowBits-1:0] pixel_row;
  } in_beat_t;

  typedef struct packed {
    logic [CountBits-1:0] bin_count;
    logic [CountBits-1:0] peak_hits;
    logic [HitsBits-1:0]  hits_recorded;
  } out_beat_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic upd;
    logic look;
    logic clear;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic len_zero;
    logic stop;
    logic at_end;
    logic read_ok;
  } orbit_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fractal_orbit_density_histogram.sv =====
// Orbit density histogram: one request at a time. A trace alternates a multiply state and an
// update state for each squaring step, waits for the last bin update to drain, then loads the
// result beat; a bin read passes through a lookup state before its result loads, and a clear
// zeroes one bin per cycle. The next request is taken in the idle state after the result loads.
// Reset sets orbit_length to 1000 and starts a clear sweep of all 98,304 bins of the bin memory;
// in_stall_o stays high until it ends.
`default_nettype none

module fractal_orbit_density_histogram (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  fodh_pkg::in_beat_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output fodh_pkg::out_beat_t         out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fodh_pkg::ApbAw-1:0]  paddr,
  input  logic [fodh_pkg::ApbDw-1:0]  pwdata,
  output logic [fodh_pkg::ApbDw-1:0]  prdata,
  output logic                        pready
);
  import fodh_pkg::*;

  logic [LenBits-1:0]   orbit_len_q;
  logic                 out_valid_q;
  out_beat_t            out_q, out_d;
  logic                 out_free;
  logic                 len_sel;

  ctrl_cmd_t            cmd;
  orbit_sts_t           sts;
  logic                 hit_valid;
  logic [BinAw-1:0]     hit_idx;
  logic [BinAw-1:0]     look_idx;
  logic [HitsBits-1:0]  hits;
  logic [CountBits-1:0] hist_rdata;
  logic [CountBits-1:0] peak;
  logic                 hist_busy;

  assign pready  = 1'b1;
  assign len_sel = ({paddr[ApbAw-1:2], 2'b00} == REG_ORBIT_LENGTH);
  assign prdata  = len_sel ? {{(ApbDw-LenBits){1'b0}}, orbit_len_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orbit_len_q <= OrbitLenReset;
    end else if (psel && penable && pwrite && len_sel) begin
      orbit_len_q <= pwdata[LenBits-1:0];
    end
  end

  fodh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .opcode_i    (in_data_i.opcode),
    .sts_i       (sts),
    .hist_busy_i (hist_busy),
    .out_free_i  (out_free),
    .in_stall_o  (in_stall_o),
    .cmd_o       (cmd)
  );

  fodh_orbit u_orbit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .beat_i      (in_data_i),
    .orbit_len_i (orbit_len_q),
    .sts_o       (sts),
    .hit_valid_o (hit_valid),
    .hit_idx_o   (hit_idx),
    .look_idx_o  (look_idx),
    .hits_o      (hits)
  );

  fodh_hist u_hist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hit_valid_i (hit_valid),
    .hit_idx_i   (hit_idx),
    .look_en_i   (cmd.look && sts.read_ok),
    .look_idx_i  (look_idx),
    .clear_i     (cmd.clear),
    .rdata_o     (hist_rdata),
    .peak_o      (peak),
    .busy_o      (hist_busy)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_d.bin_count     = sts.read_ok ? hist_rdata : '0;
    out_d.peak_hits     = peak;
    out_d.hits_recorded = hits;
  end

  always_ff @(posedge clk_i) begin
    if (cmd.emit) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== hw/rtl/fodh_hist.sv =====
// Histogram bin memory with read-modify-write increment, peak tracking and clear sweep.
// Depends on fodh_pkg and the assertion macro header.
`default_nettype none
`include "fractal_orbit_density_histogram_assert.svh"

module fodh_hist (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           hit_valid_i,
  input  logic [fodh_pkg::BinAw-1:0]     hit_idx_i,
  input  logic                           look_en_i,
  input  logic [fodh_pkg::BinAw-1:0]     look_idx_i,
  input  logic                           clear_i,
  output logic [fodh_pkg::CountBits-1:0] rdata_o,
  output logic [fodh_pkg::CountBits-1:0] peak_o,
  output logic                           busy_o
);
  import fodh_pkg::*;

  logic [CountBits-1:0] bin_mem [BinTotal];
  logic [CountBits-1:0] rdata_q;
  logic [CountBits-1:0] peak_q, peak_d;
  logic                 wr_pend_q, wr_pend_d;
  logic [BinAw-1:0]     wr_idx_q;
  logic                 clearing_q, clearing_d;
  logic [BinAw-1:0]     sweep_q, sweep_d;

  logic                 rd_en;
  logic [BinAw-1:0]     rd_addr;
  logic                 we;
  logic [BinAw-1:0]     wa;
  logic [CountBits-1:0] wd;
  logic [CountBits-1:0] inc;

  assign rd_en   = hit_valid_i | look_en_i;
  assign rd_addr = hit_valid_i ? hit_idx_i : look_idx_i;
  assign inc     = (rdata_q == CountMax) ? rdata_q : rdata_q + CountBits'(1);
  assign we      = clearing_q | wr_pend_q;
  assign wa      = clearing_q ? sweep_q : wr_idx_q;
  assign wd      = clearing_q ? '0 : inc;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= bin_mem[rd_addr];
    end
    if (we) begin
      bin_mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit_valid_i) begin
      wr_idx_q <= hit_idx_i;
    end
  end

  always_comb begin
    wr_pend_d  = hit_valid_i;
    clearing_d = clearing_q;
    sweep_d    = sweep_q;
    peak_d     = peak_q;
    if (clear_i) begin
      clearing_d = 1'b1;
      sweep_d    = '0;
      peak_d     = '0;
    end else if (clearing_q) begin
      sweep_d = sweep_q + BinAw'(1);
      if (sweep_q == BinAw'(BinTotal - 1)) begin
        clearing_d = 1'b0;
      end
    end else if (wr_pend_q && (inc > peak_q)) begin
      peak_d = inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_pend_q  <= 1'b0;
      clearing_q <= 1'b1;
      sweep_q    <= '0;
      peak_q     <= '0;
    end else begin
      wr_pend_q  <= wr_pend_d;
      clearing_q <= clearing_d;
      sweep_q    <= sweep_d;
      peak_q     <= peak_d;
    end
  end

  assign rdata_o = rdata_q;
  assign peak_o  = peak_q;
  assign busy_o  = clearing_q | wr_pend_q | hit_valid_i;

  `FODH_ASSERT(a_no_clear_rmw, !(clearing_q && wr_pend_q), "increment overlaps clear sweep")
  `FODH_ASSERT_NEXT(a_peak_covers, wr_pend_q && !clear_i, peak_q >= $past(inc), "peak below new count")

endmodule

`default_nettype wire

// ===== hw/rtl/fodh_orbit.sv =====
// Orbit datapath: start point, complex squaring with registered products, hit test and bin index.
// Depends on fodh_pkg and the assertion macro header.
`default_nettype none
`include "fractal_orbit_density_histogram_assert.svh"

module fodh_orbit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fodh_pkg::ctrl_cmd_t           cmd_i,
  input  fodh_pkg::in_beat_t            beat_i,
  input  logic [fodh_pkg::LenBits-1:0]  orbit_len_i,
  output fodh_pkg::orbit_sts_t          sts_o,
  output logic                          hit_valid_o,
  output logic [fodh_pkg::BinAw-1:0]    hit_idx_o,
  output logic [fodh_pkg::BinAw-1:0]    look_idx_o,
  output logic [fodh_pkg::HitsBits-1:0] hits_o
);
  import fodh_pkg::*;

  localparam int CfW = ColBits + FracBits;
  localparam int RfW = RowBits + FracBits;
  localparam int UW  = FracBits + 2;
  localparam int PrW = UW + ScaleBits;

  logic [1:0]              op_q;
  logic [ColBits-1:0]      col_q;
  logic [RowBits-1:0]      row_q;
  logic signed [ZW-1:0]    cr_q, ci_q, zr_q, zi_q;
  logic [LenBits-1:0]      n_q;
  logic [HitsBits-1:0]     hits_q;
  logic                    hit_q;
  logic [BinAw-1:0]        hit_idx_q;
  logic signed [PW-1:0]    p_rr_q, p_ii_q, p_re_q, p_im_q;
  logic                    oob_q;

  logic [CfW-1:0]          col_fx;
  logic [RfW-1:0]          row_fx;
  logic signed [ZW-1:0]    cr_d, ci_d;
  logic signed [ZW:0]      s_w, d_w, t_w;
  logic signed [MW-1:0]    a_r, a_i, a_s, a_d, a_t;
  logic                    oob_d;
  logic signed [PW-1:0]    sq_sum, re_sh, im_sh;
  logic signed [ZW-1:0]    nr, ni;
  logic                    stop, win;
  logic [UW-1:0]           ur, ui;
  logic [PrW-1:0]          col_prod, row_prod;
  logic [ColBits-1:0]      bcol;
  logic [RowBits-1:0]      brow;
  logic [BinAw-1:0]        idx;
  logic [LenBits:0]        n_inc;

  assign col_fx = {beat_i.pixel_col, {FracBits{1'b0}}} / GridScale;
  assign row_fx = {beat_i.pixel_row, {FracBits{1'b0}}} / GridScale;
  assign cr_d   = $signed(ZW'(col_fx)) - FxTwo;
  assign ci_d   = $signed(ZW'(row_fx)) - FxOne;

  assign s_w   = zr_q + zi_q;
  assign d_w   = zr_q - zi_q;
  assign t_w   = {zr_q, 1'b0};
  assign a_r   = MW'(zr_q);
  assign a_i   = MW'(zi_q);
  assign a_s   = MW'(s_w);
  assign a_d   = MW'(d_w);
  assign a_t   = MW'(t_w);
  assign oob_d = (zr_q > FxFour) || (zr_q < FxMinusFour) ||
                 (zi_q > FxFour) || (zi_q < FxMinusFour);

  assign sq_sum = (p_rr_q >>> FracBits) + (p_ii_q >>> FracBits);
  assign stop   = oob_q || (sq_sum > SqLimit);
  assign re_sh  = p_re_q >>> FracBits;
  assign im_sh  = p_im_q >>> FracBits;
  assign nr     = ZW'(re_sh) + cr_q;
  assign ni     = ZW'(im_sh) + ci_q;
  assign win    = (nr >= FxMinusTwo) && (nr < FxOne) && (ni >= FxMinusOne) && (ni < FxOne);

  assign ur       = UW'(nr + FxTwo);
  assign ui       = UW'(ni + FxOne);
  assign col_prod = PrW'(ur) * PrW'(GridScale);
  assign row_prod = PrW'(ui) * PrW'(GridScale);
  assign bcol     = ColBits'(col_prod >> FracBits);
  assign brow     = RowBits'(row_prod >> FracBits);
  assign idx      = BinAw'(bcol) * BinAw'(GridRows) + BinAw'(brow);

  assign n_inc    = {1'b0, n_q} + (LenBits+1)'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= beat_i.opcode;
      col_q <= beat_i.pixel_col;
      row_q <= beat_i.pixel_row;
      cr_q  <= cr_d;
      ci_q  <= ci_d;
      zr_q  <= cr_d;
      zi_q  <= ci_d;
    end else if (cmd_i.upd && !stop) begin
      zr_q <= nr;
      zi_q <= ni;
    end
    if (cmd_i.mul) begin
      p_rr_q <= a_r * a_r;
      p_ii_q <= a_i * a_i;
      p_re_q <= a_s * a_d;
      p_im_q <= a_t * a_i;
      oob_q  <= oob_d;
    end
    if (cmd_i.upd) begin
      hit_idx_q <= idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q    <= '0;
      hits_q <= '0;
      hit_q  <= 1'b0;
    end else begin
      hit_q <= cmd_i.upd && !stop && win;
      if (cmd_i.load) begin
        n_q    <= '0;
        hits_q <= '0;
      end else if (cmd_i.upd && !stop) begin
        n_q <= n_inc[LenBits-1:0];
        if (win && (hits_q != '1)) begin
          hits_q <= hits_q + HitsBits'(1);
        end
      end
    end
  end

  assign sts_o.len_zero = (orbit_len_i == '0);
  assign sts_o.stop     = stop;
  assign sts_o.at_end   = (n_inc == {1'b0, orbit_len_i});
  assign sts_o.read_ok  = (op_q == OP_READ) && (int'(col_q) < GridCols) &&
                          (int'(row_q) < GridRows);

  assign hit_valid_o = hit_q;
  assign hit_idx_o   = hit_idx_q;
  assign look_idx_o  = BinAw'(col_q) * BinAw'(GridRows) + BinAw'(row_q);
  assign hits_o      = hits_q;

  `FODH_ASSERT_NEXT(a_hit_pulse, hit_q, !hit_q, "hit pulse longer than one cycle")

endmodule

`default_nettype wire

// ===== hw/rtl/fodh_ctrl.sv =====
// Controller state machine: sequences trace iterations, bin reads, clears and result beats.
// Depends on fodh_pkg and the assertion macro header.
`default_nettype none
`include "fractal_orbit_density_histogram_assert.svh"

module fodh_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [1:0]           opcode_i,
  input  fodh_pkg::orbit_sts_t sts_i,
  input  logic                 hist_busy_i,
  input  logic                 out_free_i,
  output logic                 in_stall_o,
  output fodh_pkg::ctrl_cmd_t  cmd_o
);
  import fodh_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = hist_busy_i;
        if (in_valid_i && !hist_busy_i) begin
          cmd_o.load = 1'b1;
          case (opcode_i)
            OP_TRACE: state_d = sts_i.len_zero ? ST_WAIT : ST_MUL;
            OP_READ:  state_d = ST_LOOK;
            OP_CLEAR: begin
              cmd_o.clear = 1'b1;
              state_d     = ST_WAIT;
            end
            default:  state_d = ST_DONE;
          endcase
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = (sts_i.stop || sts_i.at_end) ? ST_WAIT : ST_MUL;
      end
      ST_LOOK: begin
        cmd_o.look = 1'b1;
        state_d    = ST_DONE;
      end
      ST_WAIT: begin
        if (!hist_busy_i) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  `FODH_ASSERT_NEXT(a_stop_drains, state_q == ST_UPD && sts_i.stop, state_q == ST_WAIT, "early exit did not drain")
  `FODH_ASSERT_NEXT(a_look_done, state_q == ST_LOOK, state_q == ST_DONE, "bin read did not complete")

endmodule

`default_nettype wire

// ===== tb/sv/fractal_orbit_density_histogram_tb.sv =====
// Self-checking testbench of the orbit density histogram: sends trace, read and clear requests,
// programs orbit_length over APB, predicts every result beat and compares it field by field.
// Depends on fodh_pkg and fractal_orbit_density_histogram.
`timescale 1ns / 1ps

module fractal_orbit_density_histogram_tb;
  import fodh_pkg::*;

  localparam int unsigned CycleLimit = 4_000_000;
  localparam int unsigned HitsMax    = (1 << HitsBits) - 1;
  localparam logic [1:0]  OpUnused   = 2'd3;
  localparam longint      One        = longint'(1) <<< FracBits;

  logic              clk_i    = 1'b0;
  logic              rst_ni   = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_beat_t          in_data  = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_beat_t         out_data;
  logic              psel     = 1'b0;
  logic              penable  = 1'b0;
  logic              pwrite   = 1'b0;
  logic [ApbAw-1:0]  paddr    = '0;
  logic [ApbDw-1:0]  pwdata   = '0;
  logic [ApbDw-1:0]  prdata;
  logic              pready;

  int unsigned          bin_hist [int unsigned];
  int unsigned          hit_bins [$];
  int unsigned          peak_level  = 0;
  logic [LenBits-1:0]   orbit_len   = OrbitLenReset;
  out_beat_t            hist_answers [$];
  out_beat_t            want_beat;
  int unsigned          mismatches  = 0;
  int unsigned          cycle_count = 0;
  int unsigned          burst_left  = 0;
  int unsigned          stall_pct   = 0;

  fractal_orbit_density_histogram dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned bin_at(int unsigned idx);
    return bin_hist.exists(idx) ? bin_hist[idx] : 0;
  endfunction

  function automatic void bump_bin(longint re, longint im);
    int unsigned col;
    int unsigned row;
    int unsigned idx;
    col = int'(((re + 2 * One) * GridScale) >>> FracBits);
    row = int'(((im + One) * GridScale) >>> FracBits);
    idx = col * GridRows + row;
    if (!bin_hist.exists(idx)) begin
      bin_hist[idx] = 0;
      hit_bins.push_back(idx);
    end
    if (bin_hist[idx] != CountMax) bin_hist[idx]++;
    if (bin_hist[idx] > peak_level) peak_level = bin_hist[idx];
  endfunction

  function automatic int unsigned orbit_hits(int unsigned col, int unsigned row);
    longint      cr;
    longint      ci;
    longint      zr;
    longint      zi;
    longint      nr;
    longint      ni;
    int unsigned hits;
    int unsigned step;
    cr = ((longint'(col) <<< FracBits) / GridScale) - 2 * One;
    ci = ((longint'(row) <<< FracBits) / GridScale) - One;
    zr = cr;
    zi = ci;
    hits = 0;
    for (step = 0; step < orbit_len; step++) begin
      if (zr > 4 * One || zr < -4 * One || zi > 4 * One || zi < -4 * One) break;
      if (((zr * zr) >>> FracBits) + ((zi * zi) >>> FracBits) > 16 * One) break;
      nr = (((zr + zi) * (zr - zi)) >>> FracBits) + cr;
      ni = (((2 * zr) * zi) >>> FracBits) + ci;
      if (nr >= -2 * One && nr < One && ni >= -One && ni < One) begin
        bump_bin(nr, ni);
        if (hits < HitsMax) hits++;
      end
      zr = nr;
      zi = ni;
    end
    return hits;
  endfunction

  function automatic out_beat_t histogram_answer(in_beat_t beat);
    out_beat_t ans;
    ans = '0;
    case (beat.opcode)
      OP_TRACE: begin
        ans.hits_recorded = HitsBits'(orbit_hits(beat.pixel_col, beat.pixel_row));
      end
      OP_READ: begin
        if (beat.pixel_col < GridCols && beat.pixel_row < GridRows)
          ans.bin_count = bin_at(beat.pixel_col * GridRows + beat.pixel_row);
      end
      OP_CLEAR: begin
        bin_hist.delete();
        hit_bins.delete();
        peak_level = 0;
      end
      default: ;
    endcase
    ans.peak_hits = peak_level;
    return ans;
  endfunction

  function automatic in_beat_t beat_of(logic [1:0] op, logic [ColBits-1:0] col,
                                       logic [RowBits-1:0] row);
    in_beat_t beat;
    beat.opcode    = op;
    beat.pixel_col = col;
    beat.pixel_row = row;
    return beat;
  endfunction

  function automatic in_beat_t random_request();
    in_beat_t    beat;
    int unsigned pick;
    int unsigned idx;
    pick = $urandom_range(0, 99);
    beat.pixel_col = ColBits'($urandom_range(0, 511));
    beat.pixel_row = RowBits'($urandom);
    if (pick < 70) begin
      beat.opcode = OP_TRACE;
      if (pick < 40) begin
        beat.pixel_col = ColBits'($urandom_range(100, 300));
        beat.pixel_row = RowBits'($urandom_range(40, 216));
      end else if (pick < 46) begin
        beat.pixel_col = ColBits'($urandom_range(GridCols, 511));
      end
    end else if (pick < 97) begin
      beat.opcode = OP_READ;
      if (hit_bins.size() != 0 && pick < 90) begin
        idx = hit_bins[$urandom_range(0, hit_bins.size() - 1)];
        beat.pixel_col = ColBits'(idx / GridRows);
        beat.pixel_row = RowBits'(idx % GridRows);
      end
    end else begin
      beat.opcode = OpUnused;
    end
    return beat;
  endfunction

  task automatic send_beat(input in_beat_t beat);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk_i); while (in_stall);
    hist_answers.push_back(histogram_answer(beat));
  endtask

  task automatic drain_answers();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (hist_answers.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic check_orbit_length();
    logic [ApbDw-1:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= REG_ORBIT_LENGTH;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (readback !== ApbDw'(orbit_len)) begin
      $display("%0t: orbit_length expected %0d, got %0d", $time, orbit_len, readback);
      mismatches++;
    end
  endtask

  task automatic write_orbit_length(input logic [LenBits-1:0] len);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_ORBIT_LENGTH;
    pwdata  <= ApbDw'(len);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    orbit_len = len;
    @(posedge clk_i);
    check_orbit_length();
  endtask

  task automatic run_directed();
    send_beat(beat_of(OP_TRACE, 256, 128));
    send_beat(beat_of(OP_READ, 256, 128));
    send_beat(beat_of(OP_TRACE, 128, 128));
    send_beat(beat_of(OP_TRACE, 0, 128));
    send_beat(beat_of(OP_TRACE, 0, 0));
    send_beat(beat_of(OP_TRACE, 383, 255));
    send_beat(beat_of(OP_TRACE, 511, 255));
    send_beat(beat_of(OP_TRACE, 511, 0));
    send_beat(beat_of(OP_TRACE, 0, 255));
    send_beat(beat_of(OP_TRACE, 300, 200));
    send_beat(beat_of(OP_READ, 0, 0));
    send_beat(beat_of(OP_READ, 128, 128));
    send_beat(beat_of(OP_READ, 256, 128));
    send_beat(beat_of(OP_READ, 383, 255));
    send_beat(beat_of(OP_READ, 384, 0));
    send_beat(beat_of(OP_READ, 511, 255));
    send_beat(beat_of(OpUnused, 511, 255));
    send_beat(beat_of(OpUnused, 0, 0));
    send_beat(beat_of(OP_CLEAR, 511, 255));
    send_beat(beat_of(OP_READ, 256, 128));
    send_beat(beat_of(OP_TRACE, 256, 128));
    send_beat(beat_of(OP_READ, 256, 128));
  endtask

  task automatic run_length_extremes();
    drain_answers();
    write_orbit_length(16'd0);
    send_beat(beat_of(OP_TRACE, 256, 128));
    send_beat(beat_of(OP_TRACE, 511, 255));
    drain_answers();
    write_orbit_length(16'd1);
    send_beat(beat_of(OP_TRACE, 256, 128));
    send_beat(beat_of(OP_TRACE, 0, 0));
    send_beat(beat_of(OP_READ, 256, 128));
    drain_answers();
    write_orbit_length(16'hFFFF);
    send_beat(beat_of(OP_TRACE, 256, 128));
    send_beat(beat_of(OP_TRACE, 300, 200));
    send_beat(beat_of(OP_READ, 256, 128));
  endtask

  task automatic run_random_requests(input int unsigned count, input logic [LenBits-1:0] len,
                                     input bit with_clear);
    int unsigned clear_at;
    int unsigned k;
    drain_answers();
    write_orbit_length(len);
    clear_at = with_clear ? $urandom_range(count / 4, 3 * count / 4) : count;
    for (k = 0; k < count; k++) begin
      if (k == clear_at) send_beat(beat_of(OP_CLEAR, ColBits'($urandom), RowBits'($urandom)));
      else send_beat(random_request());
      if ($urandom_range(0, 39) == 0) drain_answers();
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count % 64 == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 30;
        2: stall_pct = 60;
        default: stall_pct = 90;
      endcase
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
    if (cycle_count >= CycleLimit) begin
      $display("fractal_orbit_density_histogram_tb failed");
      $finish;
    end
  end

  function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (hist_answers.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got %p", $time, out_data);
        mismatches++;
      end else begin
        want_beat = hist_answers.pop_front();
        compare_field("bin_count", want_beat.bin_count, out_data.bin_count);
        compare_field("peak_hits", want_beat.peak_hits, out_data.peak_hits);
        compare_field("hits_recorded", 32'(want_beat.hits_recorded),
                      32'(out_data.hits_recorded));
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_orbit_length();
    run_directed();
    run_length_extremes();
    run_random_requests(50, 16'd1000, 1'b0);
    run_random_requests(100, 16'd1, 1'b0);
    run_random_requests(180, LenBits'($urandom_range(2, 48)), 1'b1);
    run_random_requests(150, 16'd256, 1'b0);
    drain_answers();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("fractal_orbit_density_histogram_tb passed");
    end else begin
      $display("fractal_orbit_density_histogram_tb failed");
    end
    $finish;
  end

endmodule

// ===== fractal_orbit_density_histogram.f =====
+incdir+hw/rtl
hw/rtl/fodh_pkg.sv
hw/rtl/fodh_hist.sv
hw/rtl/fodh_orbit.sv
hw/rtl/fodh_ctrl.sv
hw/rtl/fractal_orbit_density_histogram.sv
tb/sv/fractal_orbit_density_histogram_tb.sv
